### hdl/mcc2d_pkg.sv
// Package with shared types and constants for the 2D correlation and convolution block.
`timescale 1ns / 1ps

package mcc2d_pkg;

  // Widths of the item fields and of the configuration port.
  localparam int ROW_W   = 7;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 32;
  localparam int RES_W   = 40;
  localparam int ADDR_W  = 5;
  localparam int PDATA_W = 32;

  // Signed width for window and tap coordinates. Sizes stay below 128 and
  // kernel offsets below 16, so every intermediate coordinate fits.
  localparam int CW = 10;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD_KERNEL = 2'd0;
  localparam logic [1:0] OP_LOAD_IMAGE  = 2'd1;
  localparam logic [1:0] OP_READ        = 2'd2;

  // Output window modes.
  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_SAME  = 2'd1;
  localparam logic [1:0] MODE_VALID = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd0;
  localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd1;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [2:0] REG_OUTPUT_MODE   = 3'd4;
  localparam logic [2:0] REG_FLIP_KERNEL   = 3'd5;

  // Register reset values.
  localparam logic [3:0] RST_KERNEL_SIZE = 4'd3;
  localparam logic [6:0] RST_IMAGE_SIZE  = 7'd32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

### hdl/matrix_correlation_conv_2d.sv
// Top level: 2D correlation or convolution with on-chip kernel and image stores.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------
// request   | in        | req_valid/req_stall  | operation, row, col, value
// response  | out       | rsp_valid/rsp_stall  | result, in_window
// config    | in        | APB psel/penable     | paddr, pwdata, prdata, pready
//
// A load item writes one entry of the kernel or image store and leaves the block
// ready for the next item. A read item inside the window walks the kernel taps,
// one tap per cycle through the shared multiply-accumulate unit, then drains the
// store read and product stages, sooner when the last taps fall on padding; its
// done state then registers the result and returns to idle for the next item.
// A read outside the window goes straight to the done state, which registers a
// zero result once the output register is free.
// Reset is synchronous and clears the control state and configuration registers;
// the datapath registers and the stores are not cleared, and the stores read as
// undefined until written.
// The block holds req_stall high while a read is in work. A finished result sits
// in the output register, so the next item is taken while it waits on rsp_stall;
// a second read then waits in its last state until the register is free.

module matrix_correlation_conv_2d #(
  parameter int MAX_KERNEL = 8,
  parameter int MAX_IMAGE  = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcc2d_pkg::ADDR_W-1:0]        paddr,
  input  logic [mcc2d_pkg::PDATA_W-1:0]       pwdata,
  output logic [mcc2d_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  // Request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          operation,
  input  logic [mcc2d_pkg::ROW_W-1:0]         row,
  input  logic [mcc2d_pkg::ROW_W-1:0]         col,
  input  logic signed [mcc2d_pkg::DATA_W-1:0] value,
  // Response channel
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [mcc2d_pkg::RES_W-1:0]  result,
  output logic                                in_window
);

  localparam int CW     = mcc2d_pkg::CW;
  localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int IDEPTH = MAX_IMAGE * MAX_IMAGE;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
  // Tap counters and kernel sizes hold values up to MAX_KERNEL.
  localparam int KCW    = $clog2(MAX_KERNEL + 1);

  // Configuration registers, kept as written so that reads return them unchanged.
  logic [3:0] kernel_height;
  logic [3:0] kernel_width;
  logic [6:0] image_height;
  logic [6:0] image_width;
  logic [1:0] output_mode;
  logic       flip_kernel;

  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_height <= mcc2d_pkg::RST_KERNEL_SIZE;
      kernel_width  <= mcc2d_pkg::RST_KERNEL_SIZE;
      image_height  <= mcc2d_pkg::RST_IMAGE_SIZE;
      image_width   <= mcc2d_pkg::RST_IMAGE_SIZE;
      output_mode   <= mcc2d_pkg::MODE_FULL;
      flip_kernel   <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        mcc2d_pkg::REG_KERNEL_HEIGHT: kernel_height <= pwdata[3:0];
        mcc2d_pkg::REG_KERNEL_WIDTH:  kernel_width  <= pwdata[3:0];
        mcc2d_pkg::REG_IMAGE_HEIGHT:  image_height  <= pwdata[6:0];
        mcc2d_pkg::REG_IMAGE_WIDTH:   image_width   <= pwdata[6:0];
        mcc2d_pkg::REG_OUTPUT_MODE:   output_mode   <= pwdata[1:0];
        mcc2d_pkg::REG_FLIP_KERNEL:   flip_kernel   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      mcc2d_pkg::REG_KERNEL_HEIGHT: prdata = {28'd0, kernel_height};
      mcc2d_pkg::REG_KERNEL_WIDTH:  prdata = {28'd0, kernel_width};
      mcc2d_pkg::REG_IMAGE_HEIGHT:  prdata = {25'd0, image_height};
      mcc2d_pkg::REG_IMAGE_WIDTH:   prdata = {25'd0, image_width};
      mcc2d_pkg::REG_OUTPUT_MODE:   prdata = {30'd0, output_mode};
      mcc2d_pkg::REG_FLIP_KERNEL:   prdata = {31'd0, flip_kernel};
      default:                      prdata = '0;
    endcase
  end

  // Effective sizes: zero counts as one, anything above the store dimension
  // counts as the store dimension.
  logic signed [CW-1:0] kh, kw, ih, iw;

  always_comb begin
    if (kernel_height == 4'd0) begin
      kh = CW'(1);
    end else if (int'(kernel_height) > MAX_KERNEL) begin
      kh = CW'(MAX_KERNEL);
    end else begin
      kh = CW'(kernel_height);
    end
    if (kernel_width == 4'd0) begin
      kw = CW'(1);
    end else if (int'(kernel_width) > MAX_KERNEL) begin
      kw = CW'(MAX_KERNEL);
    end else begin
      kw = CW'(kernel_width);
    end
    if (image_height == 7'd0) begin
      ih = CW'(1);
    end else if (int'(image_height) > MAX_IMAGE) begin
      ih = CW'(MAX_IMAGE);
    end else begin
      ih = CW'(image_height);
    end
    if (image_width == 7'd0) begin
      iw = CW'(1);
    end else if (int'(image_width) > MAX_IMAGE) begin
      iw = CW'(MAX_IMAGE);
    end else begin
      iw = CW'(image_width);
    end
  end

  // Window offset into the full-size result and window size, per axis. An
  // unknown mode behaves as the full window.
  logic signed [CW-1:0] offy, offx, hy, wx;

  always_comb begin
    priority if (output_mode == mcc2d_pkg::MODE_SAME) begin
      offy = (kh - CW'(1)) >>> 1;
      offx = (kw - CW'(1)) >>> 1;
      hy   = ih;
      wx   = iw;
    end else if (output_mode == mcc2d_pkg::MODE_VALID) begin
      offy = kh - CW'(1);
      offx = kw - CW'(1);
      hy   = ih - kh + CW'(1);
      wx   = iw - kw + CW'(1);
    end else begin
      offy = '0;
      offx = '0;
      hy   = ih + kh - CW'(1);
      wx   = iw + kw - CW'(1);
    end
  end

  // Request decode.
  logic                 accept;
  logic signed [CW-1:0] row_s, col_s;
  logic                 win;
  logic                 k_we, i_we;
  logic [KAW-1:0]       k_waddr;
  logic [IAW-1:0]       i_waddr;

  assign accept  = req_valid && !req_stall;
  assign row_s   = $signed({{(CW - mcc2d_pkg::ROW_W){1'b0}}, row});
  assign col_s   = $signed({{(CW - mcc2d_pkg::ROW_W){1'b0}}, col});
  assign win     = (row_s < hy) && (col_s < wx);
  assign k_we    = accept && (operation == mcc2d_pkg::OP_LOAD_KERNEL) &&
                   (int'(row) < MAX_KERNEL) && (int'(col) < MAX_KERNEL);
  assign i_we    = accept && (operation == mcc2d_pkg::OP_LOAD_IMAGE) &&
                   (int'(row) < MAX_IMAGE) && (int'(col) < MAX_IMAGE);
  assign k_waddr = KAW'(int'(row) * MAX_KERNEL + int'(col));
  assign i_waddr = IAW'(int'(row) * MAX_IMAGE + int'(col));

  // Sequencer state and per-read registers.
  mcc2d_pkg::state_t    state, state_next;
  logic                 issue;
  logic                 deliver;
  logic [KCW-1:0]       r_cnt, c_cnt;
  logic signed [CW-1:0] base_y, base_x;
  logic                 win_r;

  // Current tap: image coordinates, whether the tap lies on the image, and
  // the kernel entry it uses (rotated when convolving).
  logic signed [CW-1:0] tap_y, tap_x;
  logic                 tap_in;
  logic                 last_c, last_r;
  logic [KCW-1:0]       kr, kc;
  logic [KAW-1:0]       k_raddr;
  logic [IAW-1:0]       i_raddr;

  assign tap_y   = base_y + $signed({{(CW - KCW){1'b0}}, r_cnt});
  assign tap_x   = base_x + $signed({{(CW - KCW){1'b0}}, c_cnt});
  assign tap_in  = (tap_y >= 0) && (tap_y < ih) && (tap_x >= 0) && (tap_x < iw);
  assign last_c  = (c_cnt == KCW'(kw - CW'(1)));
  assign last_r  = (r_cnt == KCW'(kh - CW'(1)));
  assign kr      = flip_kernel ? (KCW'(kh - CW'(1)) - r_cnt) : r_cnt;
  assign kc      = flip_kernel ? (KCW'(kw - CW'(1)) - c_cnt) : c_cnt;
  assign k_raddr = KAW'(int'(kr) * MAX_KERNEL + int'(kc));
  assign i_raddr = IAW'(int'(tap_y) * MAX_IMAGE + int'(tap_x));

  // Multiply-accumulate pipeline: store read, product, accumulate.
  logic                         p1, p2;
  logic signed [mcc2d_pkg::DATA_W-1:0] k_rd, i_rd;
  logic signed [mcc2d_pkg::PROD_W-1:0] prod;
  logic signed [mcc2d_pkg::RES_W-1:0]  acc;

  // Kernel and image stores, one write port and one registered read port each.
  logic signed [mcc2d_pkg::DATA_W-1:0] kernel_store [KDEPTH];
  logic signed [mcc2d_pkg::DATA_W-1:0] image_store  [IDEPTH];

  always_ff @(posedge clk) begin
    if (k_we) begin
      kernel_store[k_waddr] <= value;
    end
    if (issue) begin
      k_rd <= kernel_store[k_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (i_we) begin
      image_store[i_waddr] <= value;
    end
    if (issue) begin
      i_rd <= image_store[i_raddr];
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    deliver    = 1'b0;
    unique case (state)
      mcc2d_pkg::S_IDLE: begin
        if (accept && (operation == mcc2d_pkg::OP_READ)) begin
          state_next = win ? mcc2d_pkg::S_RUN : mcc2d_pkg::S_DONE;
        end
      end
      mcc2d_pkg::S_RUN: begin
        issue = 1'b1;
        if (last_c && last_r) begin
          state_next = mcc2d_pkg::S_DRAIN;
        end
      end
      mcc2d_pkg::S_DRAIN: begin
        if (!p1 && !p2) begin
          state_next = mcc2d_pkg::S_DONE;
        end
      end
      mcc2d_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          deliver    = 1'b1;
          state_next = mcc2d_pkg::S_IDLE;
        end
      end
      default: state_next = mcc2d_pkg::S_IDLE;
    endcase
  end

  assign req_stall = (state != mcc2d_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcc2d_pkg::S_IDLE;
      p1        <= 1'b0;
      p2        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Taps that fall on zero padding never enter the accumulator.
      p1    <= issue && tap_in;
      p2    <= p1;
      if (deliver) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept && (operation == mcc2d_pkg::OP_READ)) begin
      // First tap of the full-size index: point plus offset minus kernel extent.
      base_y <= row_s + offy - (kh - CW'(1));
      base_x <= col_s + offx - (kw - CW'(1));
      win_r  <= win;
      r_cnt  <= '0;
      c_cnt  <= '0;
      acc    <= '0;
    end else begin
      if (issue) begin
        if (last_c) begin
          c_cnt <= '0;
          r_cnt <= r_cnt + KCW'(1);
        end else begin
          c_cnt <= c_cnt + KCW'(1);
        end
      end
      if (p2) begin
        acc <= acc + {{(mcc2d_pkg::RES_W - mcc2d_pkg::PROD_W){prod[mcc2d_pkg::PROD_W-1]}},
                      prod};
      end
    end
    if (p1) begin
      prod <= k_rd * i_rd;
    end
    if (deliver) begin
      result    <= win_r ? acc : '0;
      in_window <= win_r;
    end
  end

endmodule

### hdl/mcc2d_checker.sv
// Port-level checker for the 2D correlation block and its bind statement.
`timescale 1ns / 1ps

module mcc2d_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                pready,
  input logic                                req_valid,
  input logic                                req_stall,
  input logic [1:0]                          operation,
  input logic                                rsp_valid,
  input logic                                rsp_stall,
  input logic signed [mcc2d_pkg::RES_W-1:0]  result,
  input logic                                in_window
);

  // A response held back by the receiver keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(result) && $stable(in_window))
    else $error("response changed while stalled");

  // A point outside the window always answers with a zero sum.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !in_window |-> result == '0)
    else $error("nonzero result outside the window");

  // An accepted read keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (operation == mcc2d_pkg::OP_READ) |=> req_stall)
    else $error("read item did not hold the request channel");

  // After an accepted load the block is ready again in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (operation == mcc2d_pkg::OP_LOAD_KERNEL ||
    operation == mcc2d_pkg::OP_LOAD_IMAGE) |=> !req_stall && pready)
    else $error("load item did not complete in one cycle");

endmodule

bind matrix_correlation_conv_2d mcc2d_checker u_mcc2d_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .operation (operation),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .result    (result),
  .in_window (in_window)
);
